### hw/rtl/htfc_pkg.sv
package htfc_pkg;

  // Position of the next byte within a six-byte reply frame.
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_TEMP_CRC = 2'd1;
  localparam status_t STATUS_HUM_CRC  = 2'd2;

  localparam logic CFG_CRC_START = 1'b0;
  localparam logic CFG_CRC_POLY  = 1'b1;

  localparam logic [7:0] CRC_START_RESET = 8'hFF;
  localparam logic [7:0] CRC_POLY_RESET  = 8'h31;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] HUM_SCALE   = 15'd12500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [14:0] HUM_OFFSET  = 15'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;

  // MSB-first CRC-8 over one byte.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ poly;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

  // Rounded quotient by 65535. Since 65535 = 2^16 - 1, the upper half plus the
  // lower half of the biased value is the remainder of the upper-half estimate,
  // and it stays below twice the divisor, so one compare corrects it.
  function automatic logic [14:0] round_div65535(input logic [30:0] x);
    logic [30:0] y;
    logic [16:0] rem;
    logic [14:0] q;
    y   = x + 31'd32767;
    rem = 17'(y[15:0]) + 17'(y[30:16]);
    q   = y[30:16];
    if (rem >= 17'd65535) begin
      q = q + 15'd1;
    end
    return q;
  endfunction

endpackage

### hw/rtl/htfc_if.sv
interface htfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;

  modport source (output valid, output status, output temperature_centi,
                  output humidity_centi, input ready);
  modport sink   (input valid, input status, input temperature_centi,
                  input humidity_centi, output ready);
endinterface

### hw/rtl/humidity_temp_frame_checker.sv
// Humidity/temperature sensor reply checker.
// The in_byte channel takes the six reply bytes in order: temperature word
// (high byte first), its CRC-8, humidity word (high byte first), its CRC-8.
// A request with frame_start set is taken as the first byte of a new frame.
// After the sixth byte one request leaves on out_result: a status (ok,
// temperature CRC error, humidity CRC error) and both readings in hundredths.
// On a CRC error both readings are zero.
// cfg_we/cfg_index/cfg_wdata write the CRC start value (index 0) and the
// CRC polynomial (index 1); write them only while the block is idle.
// Throughput is one byte per cycle unless a sixth byte waits on a held result.
// The result is registered and appears in the cycle after the sixth byte is
// taken. Each word is scaled by a single constant multiplier as its low byte
// arrives; rounding of both words and the humidity clamp follow with byte six.
// When the receiver stalls, the result is held and input bytes keep being
// taken until a sixth byte arrives that would need the busy result register.
// Synchronous reset clears the frame position, the result valid flag and
// restores the register defaults (start 0xFF, polynomial 0x31).
module humidity_temp_frame_checker (
  input  logic             clk,
  input  logic             rst_n,
  htfc_in_if.sink          in_byte,
  htfc_out_if.source       out_result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_wdata
);
  import htfc_pkg::*;

  pos_t               pos_r, pos_nxt, pos_eff;
  logic [7:0]         crc_r, crc_nxt;
  logic [7:0]         hi_byte_r, hi_byte_nxt;
  logic [30:0]        t_prod_r, t_prod_nxt;
  logic [30:0]        h_prod_r, h_prod_nxt;
  logic               t_fail_r, t_fail_nxt;
  logic [7:0]         crc_start_r;
  logic [7:0]         crc_poly_r;
  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic signed [14:0] temp_r, temp_nxt;
  logic [13:0]        hum_r, hum_nxt;

  logic               accept;
  logic [7:0]         crc_base;
  logic [7:0]         crc_new;
  logic [14:0]        scale;
  logic [30:0]        product;
  logic [14:0]        t_q;
  logic [14:0]        h_q;
  logic [15:0]        temp_full;
  logic [14:0]        hum_diff;
  logic [13:0]        hum_clamped;

  // Only the last byte of a frame needs the result register to be free.
  assign in_byte.ready = out_result.ready || !out_valid_r || (pos_r != POS_H_CRC);
  assign accept        = in_byte.valid && in_byte.ready;
  assign pos_eff       = in_byte.frame_start ? POS_T_HI : pos_r;

  assign crc_base = (pos_eff == POS_T_HI || pos_eff == POS_H_HI) ? crc_start_r : crc_r;
  assign crc_new  = crc8_feed(crc_base, in_byte.data_byte, crc_poly_r);

  assign scale   = (pos_eff == POS_T_LO) ? TEMP_SCALE : HUM_SCALE;
  assign product = 31'({hi_byte_r, in_byte.data_byte}) * 31'(scale);

  assign t_q       = round_div65535(t_prod_r);
  assign h_q       = round_div65535(h_prod_r);
  assign temp_full = 16'(t_q) - TEMP_OFFSET;

  always_comb begin
    hum_diff = h_q - HUM_OFFSET;
    if (h_q < HUM_OFFSET) begin
      hum_clamped = '0;
    end else if (hum_diff > 15'(HUM_MAX)) begin
      hum_clamped = HUM_MAX;
    end else begin
      hum_clamped = hum_diff[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_HI;
      crc_r       <= CRC_START_RESET;
      t_fail_r    <= 1'b0;
      out_valid_r <= 1'b0;
      crc_start_r <= CRC_START_RESET;
      crc_poly_r  <= CRC_POLY_RESET;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      t_fail_r    <= t_fail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_CRC_START) begin
          crc_start_r <= cfg_wdata;
        end else begin
          crc_poly_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_byte_r <= hi_byte_nxt;
    t_prod_r  <= t_prod_nxt;
    h_prod_r  <= h_prod_nxt;
    status_r  <= status_nxt;
    temp_r    <= temp_nxt;
    hum_r     <= hum_nxt;
  end

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    hi_byte_nxt   = hi_byte_r;
    t_prod_nxt    = t_prod_r;
    h_prod_nxt    = h_prod_r;
    t_fail_nxt    = t_fail_r;
    status_nxt    = status_r;
    temp_nxt      = temp_r;
    hum_nxt       = hum_r;
    out_valid_nxt = out_valid_r && !out_result.ready;

    if (accept) begin
      unique case (pos_eff)
        POS_T_HI: begin
          crc_nxt     = crc_new;
          hi_byte_nxt = in_byte.data_byte;
          pos_nxt     = POS_T_LO;
        end
        POS_T_LO: begin
          crc_nxt    = crc_new;
          t_prod_nxt = product;
          pos_nxt    = POS_T_CRC;
        end
        POS_T_CRC: begin
          t_fail_nxt = (crc_r != in_byte.data_byte);
          pos_nxt    = POS_H_HI;
        end
        POS_H_HI: begin
          crc_nxt     = crc_new;
          hi_byte_nxt = in_byte.data_byte;
          pos_nxt     = POS_H_LO;
        end
        POS_H_LO: begin
          crc_nxt    = crc_new;
          h_prod_nxt = product;
          pos_nxt    = POS_H_CRC;
        end
        default: begin
          pos_nxt       = POS_T_HI;
          out_valid_nxt = 1'b1;
          if (t_fail_r) begin
            status_nxt = STATUS_TEMP_CRC;
          end else if (crc_r != in_byte.data_byte) begin
            status_nxt = STATUS_HUM_CRC;
          end else begin
            status_nxt = STATUS_OK;
          end
          if (status_nxt == STATUS_OK) begin
            temp_nxt = signed'(temp_full[14:0]);
            hum_nxt  = hum_clamped;
          end else begin
            temp_nxt = '0;
            hum_nxt  = '0;
          end
        end
      endcase
    end
  end

  assign out_result.valid             = out_valid_r;
  assign out_result.status            = status_r;
  assign out_result.temperature_centi = temp_r;
  assign out_result.humidity_centi    = hum_r;

endmodule

### hw/rtl/htfc_checker.sv
module htfc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [14:0] out_temperature_centi,
  input logic [13:0]        out_humidity_centi
);
  import htfc_pkg::*;

  // A stalled result request holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_temperature_centi) && $stable(out_humidity_centi))
    else $error("result changed while stalled");

  // A new result only follows an accepted byte.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an accepted byte");

  // A failed check reports no readings.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |->
      out_temperature_centi == 15'sd0 && out_humidity_centi == 14'd0)
    else $error("readings given with a CRC error");

  // Humidity stays clamped and the status is a known code.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_centi <= HUM_MAX &&
      (out_status == STATUS_OK || out_status == STATUS_TEMP_CRC ||
       out_status == STATUS_HUM_CRC))
    else $error("result out of range");

endmodule

bind humidity_temp_frame_checker htfc_checker u_htfc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_byte.valid),
  .in_ready              (in_byte.ready),
  .out_valid             (out_result.valid),
  .out_ready             (out_result.ready),
  .out_status            (out_result.status),
  .out_temperature_centi (out_result.temperature_centi),
  .out_humidity_centi    (out_result.humidity_centi)
);
